/* hdl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, codes and defaults for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

    // Default sizing of the tag store
    localparam int unsigned DEF_MAX_SET_BITS = 8;
    localparam int unsigned DEF_MAX_WAYS     = 8;
    localparam int unsigned DEF_STAMP_WIDTH  = 32;

    // Fixed field widths
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned SET_CFG_W  = 4;
    localparam int unsigned BLK_CFG_W  = 5;
    localparam int unsigned WAY_CFG_W  = 4;
    // Way counts up to 16 fit in five bits
    localparam int unsigned WAY_CNT_W  = 5;
    // Block bits plus set bits stay below 64
    localparam int unsigned SHIFT_W    = 6;

    // Request type codes
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_IFETCH = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // capture request, launch set read
        logic commit;   // compare ways, write set back, update totals
        logic clear;    // write one zero row of the clearing pass
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;   // clearing pass is on its last row
    } t_sts;

endpackage

`default_nettype wire

/* hdl/sacl_ram.sv */
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer of the tag store: clearing pass after reset, then one access
// as a set read followed by compare and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sacl_pkg::t_sts i_sts,
    output sacl_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    sacl_pkg::t_state r_state;
    sacl_pkg::t_state n_state;
    logic             r_done;

    // State register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == sacl_pkg::ST_LOOKUP);
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.clear  = 1'b0;
        unique case (r_state)
            sacl_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP: begin
                o_cmd.commit = 1'b1;
                n_state      = sacl_pkg::ST_IDLE;
            end
            default: begin
                n_state = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != sacl_pkg::ST_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

/* hdl/sacl_dp.sv */
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath of the tag store: configuration registers, set memory, way
// compare, LRU victim choice, stamp counter and saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_dp #(
    parameter int unsigned MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int unsigned MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int unsigned STAMP_WIDTH  = sacl_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sacl_pkg::t_cmd                    i_cmd,
    output sacl_pkg::t_sts                         o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [sacl_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [sacl_pkg::ADDR_W-1:0]       i_address,
    output logic                                   o_hit,
    output logic                                   o_miss,
    output logic                                   o_eviction,
    output logic                                   o_store_hit,
    output logic      [sacl_pkg::TOTAL_W-1:0]      o_hit_total,
    output logic      [sacl_pkg::TOTAL_W-1:0]      o_miss_total,
    output logic      [sacl_pkg::TOTAL_W-1:0]      o_eviction_total,
    output logic                                   o_stamp_overflow
);

    localparam int unsigned DEPTH  = 1 << MAX_SET_BITS;
    localparam int unsigned SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int unsigned LINE_W = 1 + sacl_pkg::ADDR_W + STAMP_WIDTH;
    localparam int unsigned ROW_W  = MAX_WAYS * LINE_W;
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};
    localparam logic [sacl_pkg::TOTAL_W-1:0] TOTAL_MAX = {sacl_pkg::TOTAL_W{1'b1}};

    // Configuration registers
    logic [sacl_pkg::SET_CFG_W-1:0] r_set_bits;
    logic [sacl_pkg::BLK_CFG_W-1:0] r_block_bits;
    logic [sacl_pkg::WAY_CFG_W-1:0] r_ways_used;

    // Request captured at accept
    logic [sacl_pkg::REQ_W-1:0]  r_req;
    logic [sacl_pkg::ADDR_W-1:0] r_tag;
    logic [SET_AW-1:0]           r_set;
    logic [MAX_WAYS-1:0]         r_in_rng;

    // Running state
    logic [STAMP_WIDTH-1:0]       r_stamp;
    logic [sacl_pkg::TOTAL_W-1:0] r_hit_cnt;
    logic [sacl_pkg::TOTAL_W-1:0] r_miss_cnt;
    logic [sacl_pkg::TOTAL_W-1:0] r_evict_cnt;
    logic [SET_AW-1:0]            r_clr_idx;

    // Result flags
    logic r_hit;
    logic r_miss;
    logic r_evict;
    logic r_store_hit;

    // Address decode
    logic [sacl_pkg::SET_CFG_W-1:0] sb_eff;
    logic [sacl_pkg::ADDR_W-1:0]    addr_shr;
    logic [SET_AW-1:0]              set_mask;
    logic [SET_AW-1:0]              set_idx;
    logic [sacl_pkg::SHIFT_W-1:0]   tag_shift;
    logic [sacl_pkg::ADDR_W-1:0]    tag_n;
    logic [sacl_pkg::WAY_CNT_W-1:0] ways_lim;
    logic [MAX_WAYS-1:0]            in_rng_n;

    // Way compare
    logic [ROW_W-1:0]              rd_row;
    logic [ROW_W-1:0]              wr_row;
    logic [MAX_WAYS-1:0]           way_vld;
    logic [sacl_pkg::ADDR_W-1:0]   way_tag   [MAX_WAYS];
    logic [STAMP_WIDTH-1:0]        way_stamp [MAX_WAYS];
    logic [MAX_WAYS-1:0]           hit_vec;
    logic [MAX_WAYS-1:0]           hit_oh;
    logic [MAX_WAYS-1:0]           empty_vec;
    logic [MAX_WAYS-1:0]           empty_oh;
    logic [MAX_WAYS-1:0]           lru_oh;
    logic [MAX_WAYS-1:0]           sel_oh;
    logic                          found;
    logic                          have_empty;
    logic                          is_fetch;
    logic                          is_mod;
    logic [STAMP_WIDTH-1:0]        new_stamp;
    logic [1:0]                    hit_inc;
    logic [sacl_pkg::TOTAL_W+1:0]  hit_sum;

    // Memory ports
    logic              ram_we;
    logic [SET_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways_used  <= sacl_pkg::WAY_CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sacl_pkg::CFG_SET_BITS: begin
                    r_set_bits <= i_cfg_wdata[sacl_pkg::SET_CFG_W-1:0];
                end
                sacl_pkg::CFG_BLOCK_BITS: begin
                    r_block_bits <= i_cfg_wdata[sacl_pkg::BLK_CFG_W-1:0];
                end
                sacl_pkg::CFG_WAYS_USED: begin
                    r_ways_used <= i_cfg_wdata[sacl_pkg::WAY_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Split the address into set index and tag, limit the ways in use
    always_comb begin
        sb_eff = (32'(r_set_bits) > MAX_SET_BITS) ? sacl_pkg::SET_CFG_W'(MAX_SET_BITS)
                                                  : r_set_bits;
        addr_shr = i_address >> r_block_bits;
        for (int k = 0; k < SET_AW; k++) begin
            set_mask[k] = (32'(k) < 32'(sb_eff));
        end
        set_idx   = addr_shr[SET_AW-1:0] & set_mask;
        tag_shift = sacl_pkg::SHIFT_W'(r_block_bits) + sacl_pkg::SHIFT_W'(sb_eff);
        tag_n     = i_address >> tag_shift;

        if (r_ways_used == '0) begin
            ways_lim = sacl_pkg::WAY_CNT_W'(1);
        end else if (32'(r_ways_used) > MAX_WAYS) begin
            ways_lim = sacl_pkg::WAY_CNT_W'(MAX_WAYS);
        end else begin
            ways_lim = sacl_pkg::WAY_CNT_W'(r_ways_used);
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_rng_n[w] = (32'(w) < 32'(ways_lim));
        end
    end

    // Capture the request while the set read is in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_req_type;
            r_tag    <= tag_n;
            r_set    <= set_idx;
            r_in_rng <= in_rng_n;
        end
    end

    // Unpack the ways of the set row
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_vld[w]   = rd_row[w*LINE_W + LINE_W - 1];
            way_tag[w]   = rd_row[w*LINE_W + STAMP_WIDTH +: sacl_pkg::ADDR_W];
            way_stamp[w] = rd_row[w*LINE_W +: STAMP_WIDTH];
        end
    end

    // Hit search: lowest matching valid way
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_vec[w]   = r_in_rng[w] & way_vld[w] & (way_tag[w] == r_tag);
            empty_vec[w] = r_in_rng[w] & ~way_vld[w];
        end
        hit_oh     = hit_vec & (~hit_vec + MAX_WAYS'(1));
        found      = |hit_vec;
        have_empty = |empty_vec;
    end

    // Fill target: highest empty way
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            empty_oh[w] = empty_vec[w] & ~seen;
            seen        = seen | empty_vec[w];
        end
    end

    // Victim: oldest stamp, lowest way on ties
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            lru_oh[i] = r_in_rng[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (r_in_rng[j]) begin
                    if (j < i) begin
                        lru_oh[i] = lru_oh[i] & (way_stamp[i] < way_stamp[j]);
                    end else if (j > i) begin
                        lru_oh[i] = lru_oh[i] & (way_stamp[i] <= way_stamp[j]);
                    end
                end
            end
        end
    end

    // Build the row to write back
    always_comb begin
        is_fetch  = (r_req == sacl_pkg::REQ_IFETCH);
        is_mod    = (r_req == sacl_pkg::REQ_MODIFY);
        new_stamp = (r_stamp == STAMP_MAX) ? r_stamp : r_stamp + STAMP_WIDTH'(1);
        sel_oh    = found ? hit_oh : (have_empty ? empty_oh : lru_oh);
        wr_row    = rd_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (sel_oh[w]) begin
                wr_row[w*LINE_W +: STAMP_WIDTH] = new_stamp;
                if (!found) begin
                    wr_row[w*LINE_W + STAMP_WIDTH +: sacl_pkg::ADDR_W] = r_tag;
                    wr_row[w*LINE_W + LINE_W - 1]                      = 1'b1;
                end
            end
        end
        hit_inc = {1'b0, found} + {1'b0, is_mod};
        hit_sum = {2'b00, r_hit_cnt} + (sacl_pkg::TOTAL_W + 2)'(hit_inc);
    end

    // Memory write: clearing pass or write back
    always_comb begin
        ram_we    = i_cmd.clear | (i_cmd.commit & ~is_fetch);
        ram_waddr = i_cmd.clear ? r_clr_idx : r_set;
        ram_wdata = i_cmd.clear ? '0 : wr_row;
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (set_idx),
        .o_rdata (rd_row)
    );

    // Clearing pass row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + SET_AW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_idx == SET_AW'(DEPTH - 1));

    // Stamp counter and saturating totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (i_cmd.commit && !is_fetch) begin
            r_stamp   <= new_stamp;
            r_hit_cnt <= (hit_sum[sacl_pkg::TOTAL_W+1:sacl_pkg::TOTAL_W] != 2'b00)
                         ? TOTAL_MAX : hit_sum[sacl_pkg::TOTAL_W-1:0];
            if (!found && (r_miss_cnt != TOTAL_MAX)) begin
                r_miss_cnt <= r_miss_cnt + sacl_pkg::TOTAL_W'(1);
            end
            if (!found && !have_empty && (r_evict_cnt != TOTAL_MAX)) begin
                r_evict_cnt <= r_evict_cnt + sacl_pkg::TOTAL_W'(1);
            end
        end
    end

    // Hold the result flags of the last access
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit       <= ~is_fetch & found;
            r_miss      <= ~is_fetch & ~found;
            r_evict     <= ~is_fetch & ~found & ~have_empty;
            r_store_hit <= is_mod;
        end
    end

    assign o_hit            = r_hit;
    assign o_miss           = r_miss;
    assign o_eviction       = r_evict;
    assign o_store_hit      = r_store_hit;
    assign o_hit_total      = r_hit_cnt;
    assign o_miss_total     = r_miss_cnt;
    assign o_eviction_total = r_evict_cnt;
    assign o_stamp_overflow = (r_stamp == STAMP_MAX);

endmodule

`default_nettype wire

/* hdl/set_assoc_lru_cache_tag_sim_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_sim_core
// Tag store of a set-associative cache with LRU replacement by access stamps.
//
//   Channel   Signals                                    Handshake
//   --------  -----------------------------------------  -------------------
//   request   i_req_type, i_address                      start && !busy
//   result    o_hit, o_miss, o_eviction, o_store_hit,    o_done, one cycle
//             o_hit_total, o_miss_total,
//             o_eviction_total, o_stamp_overflow
//   config    i_cfg_addr, i_cfg_wdata                    i_cfg_we
//
// An access reads the set row from the set memory in the accept cycle, then
// compares the ways in use and writes the row back, except for a fetch.
// The result beat is strobed on o_done in the cycle after that; busy stays
// high until then, so no new request is taken before. The result ports hold
// until the next beat. After reset a clearing pass writes all 2^MAX_SET_BITS
// set rows (256 by default) with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_tag_sim_core #(
    parameter int unsigned MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int unsigned MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int unsigned STAMP_WIDTH  = sacl_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [sacl_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [sacl_pkg::ADDR_W-1:0]       i_address,
    output logic                                   o_done,
    output logic                                   o_hit,
    output logic                                   o_miss,
    output logic                                   o_eviction,
    output logic                                   o_store_hit,
    output logic      [sacl_pkg::TOTAL_W-1:0]      o_hit_total,
    output logic      [sacl_pkg::TOTAL_W-1:0]      o_miss_total,
    output logic      [sacl_pkg::TOTAL_W-1:0]      o_eviction_total,
    output logic                                   o_stamp_overflow
);

    sacl_pkg::t_cmd cmd;
    sacl_pkg::t_sts sts;

    // Sequencer
    sacl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Tag store datapath
    sacl_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_WIDTH  (STAMP_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_address        (i_address),
        .o_hit            (o_hit),
        .o_miss           (o_miss),
        .o_eviction       (o_eviction),
        .o_store_hit      (o_store_hit),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total),
        .o_stamp_overflow (o_stamp_overflow)
    );

    // An accepted request keeps busy high through its lookup cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not hold busy");

    // A result beat follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a lookup");

    // A data access either hits or misses; a fetch reports nothing
    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_hit != o_miss) ||
                    (!o_hit && !o_miss && !o_eviction && !o_store_hit)))
        else $error("inconsistent hit and miss flags");

    // An eviction only comes with a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_eviction) |-> o_miss)
        else $error("eviction without a miss");

endmodule

`default_nettype wire
